FILE: design/mexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg: shared types and microprogram for the modular exponentiation unit
// Holds the control word layout, the step ROM and the multiplier status.
// ----------------------------------------------------------------------------
package mexp_pkg;

	// widths fixed by the stream and register fields
	localparam int WORD_BITS_DEF = 32;
	localparam int FIELD_BITS    = 32;
	localparam int CFG_IDX_BITS  = 1;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = 1'd1;

	// register reset values
	localparam logic [FIELD_BITS-1:0] MODULUS_RST  = 32'd2;
	localparam logic [FIELD_BITS-1:0] EXPONENT_RST = 32'd1;

	// micro-operations
	typedef enum logic [2:0] {
		OP_ACCEPT,
		OP_MUL,
		OP_TEST,
		OP_LOOP,
		OP_EMIT
	} op_t;

	// multiplier operand A source
	typedef enum logic [1:0] {
		A_ONE,
		A_ACC,
		A_BASE
	} asel_t;

	// multiplier operand B source
	typedef enum logic {
		B_CIN,
		B_BASE
	} bsel_t;

	// product destination
	typedef enum logic {
		D_BASE,
		D_ACC
	} dst_t;

	localparam int STEP_BITS = 3;
	typedef logic [STEP_BITS-1:0] step_t;

	// program addresses
	localparam step_t STEP_ACCEPT = 3'd0;
	localparam step_t STEP_REDUCE = 3'd1;
	localparam step_t STEP_TEST   = 3'd2;
	localparam step_t STEP_MULT   = 3'd3;
	localparam step_t STEP_SQUARE = 3'd4;
	localparam step_t STEP_LOOP   = 3'd5;
	localparam step_t STEP_EMIT   = 3'd6;

	// one control word per step
	typedef struct packed {
		op_t   op;
		asel_t a_sel;
		bsel_t b_sel;
		dst_t  dst;
		step_t target;
	} ctrl_t;

	// multiplier status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

	// microprogram ROM
	//   accept -> base = cipher mod n (as 1 * cipher)
	//   per exponent bit: if bit set acc = acc * base; base = base * base
	//   emit -> back to accept
	function automatic ctrl_t prog_rom(input step_t pc);
		ctrl_t w;
		case (pc)
			STEP_ACCEPT: w = '{op: OP_ACCEPT, a_sel: A_ONE, b_sel: B_CIN, dst: D_BASE,
				target: STEP_REDUCE};
			STEP_REDUCE: w = '{op: OP_MUL, a_sel: A_ONE, b_sel: B_CIN, dst: D_BASE,
				target: STEP_TEST};
			STEP_TEST:   w = '{op: OP_TEST, a_sel: A_ONE, b_sel: B_CIN, dst: D_BASE,
				target: STEP_SQUARE};
			STEP_MULT:   w = '{op: OP_MUL, a_sel: A_ACC, b_sel: B_BASE, dst: D_ACC,
				target: STEP_SQUARE};
			STEP_SQUARE: w = '{op: OP_MUL, a_sel: A_BASE, b_sel: B_BASE, dst: D_BASE,
				target: STEP_LOOP};
			STEP_LOOP:   w = '{op: OP_LOOP, a_sel: A_ONE, b_sel: B_CIN, dst: D_BASE,
				target: STEP_TEST};
			STEP_EMIT:   w = '{op: OP_EMIT, a_sel: A_ONE, b_sel: B_CIN, dst: D_BASE,
				target: STEP_ACCEPT};
			default:     w = '{op: OP_ACCEPT, a_sel: A_ONE, b_sel: B_CIN, dst: D_BASE,
				target: STEP_REDUCE};
		endcase
		return w;
	endfunction

endpackage

FILE: design/mexp_modmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_modmul: bit-serial modular multiplier
// Computes a * b mod n by shift-add-reduce, one bit of b per cycle, MSB first.
// ----------------------------------------------------------------------------
module mexp_modmul import mexp_pkg::*; #(
	parameter int DW = WORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] a,
	input  logic [DW-1:0] b,
	input  logic [DW-1:0] n,
	output logic [DW-1:0] res,
	output mul_stat_t     stat
);

	localparam int CW = $clog2(DW);

	logic [DW-1:0] r_q, a_q, b_q, n_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;

	logic [DW:0]   dbl, r1, sum2, r2, nx;
	logic [DW-1:0] addend;
	logic [DW-1:0] r_next;

	// r = 2r mod n, then r = r + (bit ? a : 0) mod n
	always_comb begin
		nx     = {1'b0, n_q};
		dbl    = {r_q, 1'b0};
		r1     = (dbl >= nx) ? (dbl - nx) : dbl;
		addend = b_q[DW-1] ? a_q : '0;
		sum2   = {1'b0, r1[DW-1:0]} + {1'b0, addend};
		r2     = (sum2 >= nx) ? (sum2 - nx) : sum2;
		r_next = r2[DW-1:0];
	end

	// bit counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// operand and partial result registers
	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			a_q <= a;
			b_q <= b;
			n_q <= n;
		end else if (busy_q) begin
			r_q <= r_next;
			b_q <= {b_q[DW-2:0], 1'b0};
		end
	end

	assign res  = r_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule

FILE: design/modular_exponentiation.sv
`timescale 1ns / 1ps
// Throughput: one item at a time; the next is taken once the result is emitted.
// Every product is formed by the single bit-serial modular multiplier.
// Reset (arst_n low, async) clears the sequencer, output valid, modulus to 2, exponent to 1.
// ----------------------------------------------------------------------------
// modular_exponentiation: microcoded square-and-multiply exponentiation unit
// Gives plain = cipher ^ exponent mod modulus, scanning exponent bits LSB first.
// ----------------------------------------------------------------------------
module modular_exponentiation import mexp_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [FIELD_BITS-1:0]   cfg_data,
	// input stream
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [FIELD_BITS-1:0]   s_tdata,   // [31:0] cipher_value
	input  logic                    s_tlast,   // final_item
	// result stream
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [FIELD_BITS-1:0]   m_tdata,   // [31:0] plain_value
	output logic                    m_tlast    // last_plain
);

	localparam int DW = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
	localparam int CW = $clog2(DW);

	// configuration registers
	logic [DW-1:0] mod_q, exp_q;

	// sequencer and datapath registers
	step_t         pc_q;
	ctrl_t         ctrl;
	logic [DW-1:0] cin_q, base_q, acc_q;
	logic [CW-1:0] bit_q;
	logic          last_q;

	// output register
	logic                  out_valid_q, out_last_q;
	logic [FIELD_BITS-1:0] out_data_q;
	logic                  out_free, out_load;

	// multiplier interface
	logic          mul_start;
	logic [DW-1:0] mul_a, mul_b, mul_res;
	mul_stat_t     mul_stat;

	assign ctrl     = prog_rom(pc_q);
	assign s_tready = (ctrl.op == OP_ACCEPT);
	assign out_free = !out_valid_q || m_tready;
	assign out_load = (ctrl.op == OP_EMIT) && out_free;

	// start a product unless one is running or just finished
	assign mul_start = (ctrl.op == OP_MUL) && !mul_stat.busy && !mul_stat.done;

	// operand selection
	always_comb begin
		case (ctrl.a_sel)
			A_ONE:   mul_a = DW'(1);
			A_ACC:   mul_a = acc_q;
			A_BASE:  mul_a = base_q;
			default: mul_a = DW'(1);
		endcase
		case (ctrl.b_sel)
			B_CIN:   mul_b = cin_q;
			B_BASE:  mul_b = base_q;
			default: mul_b = cin_q;
		endcase
	end

	mexp_modmul #(
		.DW(DW)
	) u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.n      (mod_q),
		.res    (mul_res),
		.stat   (mul_stat)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MODULUS_RST[DW-1:0];
			exp_q <= EXPONENT_RST[DW-1:0];
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODULUS:  mod_q <= cfg_data[DW-1:0];
				REG_EXPONENT: exp_q <= cfg_data[DW-1:0];
				default:      ;
			endcase
		end
	end

	// step counter, bit counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= STEP_ACCEPT;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// set on load, cleared once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (ctrl.op)
				OP_ACCEPT: begin
					if (s_tvalid) begin
						bit_q <= '0;
						pc_q  <= ctrl.target;
					end
				end
				OP_MUL: begin
					if (mul_stat.done) begin
						pc_q <= ctrl.target;
					end
				end
				OP_TEST: begin
					if (exp_q[bit_q]) begin
						pc_q <= pc_q + 1'b1;
					end else begin
						pc_q <= ctrl.target;
					end
				end
				OP_LOOP: begin
					if (bit_q == CW'(DW - 1)) begin
						pc_q <= pc_q + 1'b1;
					end else begin
						bit_q <= bit_q + 1'b1;
						pc_q  <= ctrl.target;
					end
				end
				OP_EMIT: begin
					if (out_free) begin
						pc_q <= ctrl.target;
					end
				end
				default: pc_q <= STEP_ACCEPT;
			endcase
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if ((ctrl.op == OP_ACCEPT) && s_tvalid) begin
			cin_q  <= s_tdata[DW-1:0];
			last_q <= s_tlast;
			acc_q  <= DW'(1);
		end
		if ((ctrl.op == OP_MUL) && mul_stat.done) begin
			if (ctrl.dst == D_ACC) begin
				acc_q <= mul_res;
			end else begin
				base_q <= mul_res;
			end
		end
		// a modulus below two yields zero
		if (out_load) begin
			out_data_q <= (mod_q < DW'(2)) ? '0 : FIELD_BITS'(acc_q);
			out_last_q <= last_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	// a product is never started on top of a running one
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_stat.busy)
		else $error("multiplier started while busy");

	// a product stays below a modulus of two or more
	a_res_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_stat.done && (ctrl.op == OP_MUL) && (mod_q >= DW'(2))) |-> (mul_res < mod_q))
		else $error("product not reduced");

	// an accepted item moves the sequencer to the base reduction
	a_accept_step: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (pc_q == STEP_REDUCE))
		else $error("sequencer did not leave accept step");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !out_load)
		else $error("result register overwritten");
`endif

endmodule

FILE: tb/sv/modular_exponentiation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_tb: self-checking bench for the exponentiation unit
// Each ciphertext item is streamed in and predicted as cipher^d mod n.
// Results are compared in order against the predictions. Modulus and exponent
// are rewritten between phases while the unit is idle. Both stream sides idle
// in random bursts, except in the closing part of the run.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;
	import mexp_pkg::*;

	localparam int WATCHDOG_LIMIT = 10000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int SETTLE_CYCLES  = 4;
	localparam int RANDOM_ITEMS   = 262;
	localparam int QUIET_ITEMS    = 40;

	// expected result of one ciphertext
	typedef struct {
		logic [FIELD_BITS-1:0] plain;
		logic                  last;
	} plain_item_t;

	// predicts plaintext words and checks them in arrival order
	class plain_scoreboard;
		plain_item_t           plain_queue[$];
		logic [FIELD_BITS-1:0] modulus_reg;
		logic [FIELD_BITS-1:0] exponent_reg;
		int                    errors;

		function new();
			modulus_reg  = MODULUS_RST;
			exponent_reg = EXPONENT_RST;
			errors       = 0;
		endfunction

		function void set_register(logic [CFG_IDX_BITS-1:0] idx, logic [FIELD_BITS-1:0] value);
			if (idx == REG_MODULUS) begin
				modulus_reg = value;
			end else if (idx == REG_EXPONENT) begin
				exponent_reg = value;
			end
		endfunction

		// right-to-left square and multiply with exact 64-bit products
		function logic [FIELD_BITS-1:0] predict_plain(logic [FIELD_BITS-1:0] cipher);
			longint unsigned n;
			longint unsigned base;
			longint unsigned acc;
			n = modulus_reg;
			if (n < 2) begin
				return '0;
			end
			base = cipher % n;
			acc  = 1;
			for (int i = 0; i < FIELD_BITS; i++) begin
				if (exponent_reg[i]) begin
					acc = (acc * base) % n;
				end
				base = (base * base) % n;
			end
			return acc[FIELD_BITS-1:0];
		endfunction

		function void note_cipher(logic [FIELD_BITS-1:0] cipher, logic last);
			plain_item_t item;
			item.plain = predict_plain(cipher);
			item.last  = last;
			plain_queue = {plain_queue, item};
		endfunction

		function int pending();
			return plain_queue.size();
		endfunction

		task report_mismatch(string what);
			$display("ERROR @%0t: %s", $realtime, what);
			errors++;
		endtask

		task check_plain(logic [FIELD_BITS-1:0] plain, logic last);
			plain_item_t item;
			if (plain_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected result plain=%h last=%b", plain, last));
			end else begin
				item = plain_queue.pop_front();
				if (plain !== item.plain) begin
					report_mismatch($sformatf("plain_value got %h want %h", plain, item.plain));
				end
				if (last !== item.last) begin
					report_mismatch($sformatf("last_plain got %b want %b", last, item.last));
				end
			end
		endtask
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [FIELD_BITS-1:0]   cfg_data;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [FIELD_BITS-1:0]   s_tdata;   // [31:0] cipher_value
	logic                    s_tlast;   // final_item
	logic                    m_tvalid;
	logic                    m_tready;
	logic [FIELD_BITS-1:0]   m_tdata;   // [31:0] plain_value
	logic                    m_tlast;   // last_plain

	plain_scoreboard sb = new();
	bit              idle_on = 1'b1;
	int              stall_cycles = 0;

	modular_exponentiation dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side: check every accepted item
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_plain(m_tdata, m_tlast);
		end
	end

	// result side: random ready bursts
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 2) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end
			m_tready = 1'b1;
		end
	end

	// watchdog on cycles without any accepted item or write
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("modular_exponentiation: mismatch");
			$finish;
		end
	end

	// one register write; the caller holds the unit idle
	task write_register(logic [CFG_IDX_BITS-1:0] idx, logic [FIELD_BITS-1:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_register(idx, value);
	endtask

	// drain the unit, then load a new modulus and exponent
	task load_key(logic [FIELD_BITS-1:0] modulus, logic [FIELD_BITS-1:0] exponent);
		s_tvalid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_register(REG_MODULUS, modulus);
		write_register(REG_EXPONENT, exponent);
	endtask

	// offer one ciphertext item and wait for it to be taken
	task send_cipher(logic [FIELD_BITS-1:0] cipher, logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = cipher;
		s_tlast  = last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_cipher(cipher, last);
		@(negedge clk);
	endtask

	function logic [FIELD_BITS-1:0] pick_modulus();
		case ($urandom_range(0, 4))
			0:       return 32'hFFFF_FFFF;
			1:       return 32'd2;
			2:       return $urandom_range(2, 1000);
			default: return $urandom() | 32'd2;
		endcase
	endfunction

	function logic [FIELD_BITS-1:0] pick_exponent();
		case ($urandom_range(0, 5))
			0:       return 32'hFFFF_FFFF;
			1:       return 32'd0;
			2:       return $urandom_range(1, 70000);
			default: return $urandom();
		endcase
	endfunction

	function logic [FIELD_BITS-1:0] pick_cipher(logic [FIELD_BITS-1:0] modulus);
		case ($urandom_range(0, 6))
			0:       return 32'd0;
			1:       return 32'hFFFF_FFFF;
			2:       return modulus - 32'd1;
			3:       return modulus + $urandom_range(0, 3);
			4:       return $urandom_range(0, 15);
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int                    left;
		int                    run;
		logic [FIELD_BITS-1:0] modulus;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_MODULUS;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset key: modulus 2, exponent 1
		send_cipher(32'd0, 1'b0);
		send_cipher(32'd1, 1'b0);
		send_cipher(32'hFFFF_FFFF, 1'b1);
		send_cipher(32'd3, 1'b1);

		// widest key; cipher equal to the modulus reduces to zero
		load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_cipher(32'hFFFF_FFFF, 1'b0);
		send_cipher(32'hFFFF_FFFE, 1'b0);
		send_cipher(32'd2, 1'b1);
		send_cipher(32'd0, 1'b0);

		// zero exponent gives one
		load_key(32'hFFFF_FFFB, 32'd0);
		send_cipher(32'd12345, 1'b1);
		send_cipher(32'd0, 1'b0);

		// degenerate moduli give zero
		load_key(32'd1, 32'd5);
		send_cipher(32'd7, 1'b1);
		load_key(32'd0, 32'd3);
		send_cipher(32'd9, 1'b0);

		// cipher above the modulus is reduced first
		load_key(32'd1000003, 32'd65537);
		send_cipher(32'd5000000, 1'b0);
		send_cipher(32'd1000002, 1'b0);
		send_cipher(32'd1000003, 1'b1);

		// smallest modulus with a full exponent
		load_key(32'd2, 32'hFFFF_FFFF);
		send_cipher(32'd3, 1'b1);
		send_cipher(32'hAAAA_5555, 1'b0);

		// random keys, each for a short message of random ciphertexts
		left = RANDOM_ITEMS;
		while (left > 0) begin
			modulus = pick_modulus();
			load_key(modulus, pick_exponent());
			run = $urandom_range(8, 24);
			if (run > left) begin
				run = left;
			end
			for (int i = 0; i < run; i++) begin
				idle_on = (left > QUIET_ITEMS);
				send_cipher(pick_cipher(modulus), (i == run - 1) || ($urandom_range(0, 5) == 0));
				left--;
			end
		end
		s_tvalid = 1'b0;

		// drain and settle
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.pending() != 0) begin
			sb.report_mismatch("expected results left over");
		end
		if (sb.errors == 0) begin
			$display("modular_exponentiation: match");
		end else begin
			$display("modular_exponentiation: mismatch");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/mexp_pkg.sv
design/mexp_modmul.sv
design/modular_exponentiation.sv
tb/sv/modular_exponentiation_tb.sv
